// ===== src/spq_pkg.sv =====
package spq_pkg;

  localparam int KEY_BITS     = 32;
  localparam int DEPTH_DEF    = 16;
  localparam int TAG_BITS_DEF = 16;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic load;
    logic rd_prev;
    logic rd_head;
    logic wr_new;
    logic wr_shift;
    logic result;
  } spq_cmd_t;

  typedef struct packed {
    logic func;
    logic full;
    logic empty;
    logic pos_zero;
    logic key_le;
  } spq_stat_t;

endpackage

// ===== src/stable_min_priority_queue.sv =====
// Bounded min-priority queue of (key, tag) entries with stable order for equal keys.
// Input channel s_*: s_tuser selects the operation, low for an insert and high for a
// removal of the entry with the smallest signed key; s_tdata carries the key and tag.
// Output channel m_*: exactly one result item per input item, in order. m_tdata holds
// the removed key, the removed tag and the occupancy after the item; m_tuser holds the
// removed flag and the status code (ok, removal from empty, insert dropped when full).
// Entries sit in a circular buffer in one memory with one read and one write port.
// A removal, or an insert dropped because the queue is full, goes from the decode state
// straight to the result state, which registers its result once the output register is free.
// An insert walks from the tail toward the head: it reads one entry in the read state
// and, if that key is larger, moves it up one slot in the compare state, until it finds
// a key that is not larger or reaches the head slot, and writes the new entry there.
// One item is in work at a time; s_tready is
// high only between items. A finished result waits in the output register while the
// receiver stalls, and the next item may be accepted meanwhile, but it is not finished
// until the previous result is taken. Reset empties the queue at once and drops any
// pending result; the memory contents need no clearing.
module stable_min_priority_queue #(
  parameter int DEPTH    = spq_pkg::DEPTH_DEF,
  parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF,
  parameter int IN_W     = ((spq_pkg::KEY_BITS + TAG_BITS + 7) / 8) * 8,
  parameter int OUT_W    = ((spq_pkg::KEY_BITS + TAG_BITS + $clog2(DEPTH + 1) + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // key, tag
  input  logic             s_tuser,   // func
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // out_key, out_tag, occupancy
  output logic [2:0]       m_tuser    // removed, status
);
  import spq_pkg::*;

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spq_dp #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS),
    .IN_W     (IN_W),
    .OUT_W    (OUT_W)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule

// ===== src/spq_ctrl.sv =====
module spq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_cmd_t  cmd
);
  import spq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_DECODE  = 5'b00010,
    S_INS_RD  = 5'b00100,
    S_INS_CMP = 5'b01000,
    S_RESULT  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   m_tvalid_next;
  logic   slot_free;

  assign s_tready  = (state == S_IDLE);
  assign slot_free = !m_tvalid || m_tready;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    m_tvalid_next = m_tvalid && !m_tready;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.func) begin
          if (!stat.empty) begin
            cmd.rd_head = 1'b1;
          end
          state_next = S_RESULT;
        end else if (stat.full) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (stat.pos_zero) begin
          cmd.wr_new = 1'b1;
          state_next = S_RESULT;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (stat.key_le) begin
          cmd.wr_new = 1'b1;
          state_next = S_RESULT;
        end else begin
          cmd.wr_shift = 1'b1;
          state_next   = S_INS_RD;
        end
      end
      S_RESULT: begin
        if (slot_free) begin
          cmd.result    = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

// ===== src/spq_dp.sv =====
module spq_dp #(
  parameter int DEPTH    = spq_pkg::DEPTH_DEF,
  parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF,
  parameter int IN_W     = 48,
  parameter int OUT_W    = 56
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [IN_W-1:0]    s_tdata,
  input  logic               s_tuser,
  output logic [OUT_W-1:0]   m_tdata,
  output logic [2:0]         m_tuser,
  input  spq_pkg::spq_cmd_t  cmd,
  output spq_pkg::spq_stat_t stat
);
  import spq_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic signed [KEY_BITS-1:0] key_mem [DEPTH];
  logic [TAG_BITS-1:0]        tag_mem [DEPTH];

  logic [IDX_W-1:0]           head;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           pos;
  logic                       func_r;
  logic signed [KEY_BITS-1:0] new_key;
  logic [TAG_BITS-1:0]        new_tag;
  logic signed [KEY_BITS-1:0] rd_key;
  logic [TAG_BITS-1:0]        rd_tag;

  logic signed [KEY_BITS-1:0] res_key;
  logic [TAG_BITS-1:0]        res_tag;
  logic                       res_removed;
  logic [1:0]                 res_status;
  logic [CNT_W-1:0]           res_occ;

  logic [IDX_W-1:0]           pos_idx;
  logic [IDX_W-1:0]           prev_idx;
  logic [IDX_W-1:0]           pos_addr;
  logic [IDX_W-1:0]           prev_addr;
  logic [IDX_W-1:0]           head_inc;
  logic [IDX_W:0]             sum_pos;
  logic [IDX_W:0]             sum_prev;
  logic                       wr_en;
  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;

  assign pos_idx  = pos[IDX_W-1:0];
  assign prev_idx = pos_idx - IDX_W'(1);

  assign sum_pos  = {1'b0, head} + {1'b0, pos_idx};
  assign sum_prev = {1'b0, head} + {1'b0, prev_idx};

  always_comb begin
    if (sum_pos >= (IDX_W + 1)'(DEPTH)) begin
      pos_addr = IDX_W'(sum_pos - (IDX_W + 1)'(DEPTH));
    end else begin
      pos_addr = sum_pos[IDX_W-1:0];
    end
    if (sum_prev >= (IDX_W + 1)'(DEPTH)) begin
      prev_addr = IDX_W'(sum_prev - (IDX_W + 1)'(DEPTH));
    end else begin
      prev_addr = sum_prev[IDX_W-1:0];
    end
    if (head == IDX_W'(DEPTH - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = head + IDX_W'(1);
    end
  end

  assign wr_en   = cmd.wr_new || cmd.wr_shift;
  assign rd_en   = cmd.rd_prev || cmd.rd_head;
  assign rd_addr = cmd.rd_head ? head : prev_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[pos_addr] <= cmd.wr_new ? new_key : rd_key;
      tag_mem[pos_addr] <= cmd.wr_new ? new_tag : rd_tag;
    end
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_tag <= tag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= s_tuser;
      new_key <= s_tdata[KEY_BITS-1:0];
      new_tag <= s_tdata[KEY_BITS +: TAG_BITS];
    end
    if (cmd.result) begin
      if (func_r && (count == '0)) begin
        res_key     <= '0;
        res_tag     <= '0;
        res_removed <= 1'b0;
        res_status  <= ST_EMPTY;
        res_occ     <= count;
      end else if (func_r) begin
        res_key     <= rd_key;
        res_tag     <= rd_tag;
        res_removed <= 1'b1;
        res_status  <= ST_OK;
        res_occ     <= count - CNT_W'(1);
      end else if (count == CNT_W'(DEPTH)) begin
        res_key     <= '0;
        res_tag     <= '0;
        res_removed <= 1'b0;
        res_status  <= ST_FULL;
        res_occ     <= count;
      end else begin
        res_key     <= '0;
        res_tag     <= '0;
        res_removed <= 1'b0;
        res_status  <= ST_OK;
        res_occ     <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      pos   <= '0;
    end else begin
      if (cmd.load) begin
        pos <= count;
      end else if (cmd.wr_shift) begin
        pos <= pos - CNT_W'(1);
      end
      if (cmd.result) begin
        if (func_r) begin
          if (count != '0) begin
            count <= count - CNT_W'(1);
            head  <= head_inc;
          end
        end else if (count != CNT_W'(DEPTH)) begin
          count <= count + CNT_W'(1);
        end
      end
    end
  end

  assign stat.func     = func_r;
  assign stat.full     = (count == CNT_W'(DEPTH));
  assign stat.empty    = (count == '0);
  assign stat.pos_zero = (pos == '0);
  assign stat.key_le   = (rd_key <= new_key);

  assign m_tdata = OUT_W'({res_occ, res_tag, res_key});
  assign m_tuser = {res_status, res_removed};

endmodule
